@@ sv/mlfq_pkg.sv @@
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared codes and helpers for the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_STATE = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic {
        ACT_ENQUEUE = 1'b0,
        ACT_DEQUEUE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        PS_READY   = 2'd0,
        PS_RUNNING = 2'd1,
        PS_BLOCKED = 2'd2,
        PS_INVALID = 2'd3
    } prior_state_t;

    localparam int IdFieldW = 8;
    localparam int LvlFieldW = 2;
    localparam int QuantumW = 4;

    // Time slice of a level: doubles per level and saturates at eight.
    function automatic logic [QuantumW-1:0] level_quantum(input logic [2:0] level);
        logic [QuantumW-1:0] q;
        if (level < 3'd4) begin
            q = QuantumW'(1 << level);
        end else begin
            q = QuantumW'(8);
        end
        return q;
    endfunction

endpackage

@@ sv/multilevel_feedback_queue_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_top
// Multilevel feedback queue scheduler: LEVELS FIFO queues of process IDs.
// ----------------------------------------------------------------------------
// Every input beat is either an enqueue or a dequeue and produces exactly one
// result beat in the next cycle; a new beat is taken in every cycle while the
// result side keeps m_tready high, so one beat per cycle is sustained. The
// figure is set by the single-port ID memory, which is written on an enqueue
// or read on a dequeue once per beat with its read data registered into the
// result stage. Enqueues move a process one level down for ready or running
// and one level up for blocked; dequeues serve the lowest-numbered non-empty
// level. The ID memory is not cleared after reset; only written entries are
// ever read, so the block is ready from the first cycle out of reset.
module multilevel_feedback_queue_scheduler_top #(
    parameter int QUEUE_DEPTH = 64,
    parameter int LEVELS = 4,
    parameter int ID_WIDTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] process_id, [9:8] old_priority, [11:10] prior_state, [15:12] zero
    input  logic [15:0] s_tdata,
    // [0] action
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_id, [9:8] new_priority, [13:10] quantum, [15:14] zero
    output logic [15:0] m_tdata,
    // [1:0] status
    output mlfq_pkg::status_t m_tuser
);

    import mlfq_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam int LvlW = $clog2(LEVELS);
    localparam int AddrW = LvlW + PtrW;
    localparam int StoreW = (ID_WIDTH < IdFieldW) ? ID_WIDTH : IdFieldW;
    localparam logic [IdFieldW-1:0] IdMask =
        (ID_WIDTH >= IdFieldW) ? {IdFieldW{1'b1}} : IdFieldW'((1 << ID_WIDTH) - 1);
    localparam logic [LvlW-1:0] LastLvl = LvlW'(LEVELS - 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

    logic [PtrW-1:0] head_reg [LEVELS];
    logic [PtrW-1:0] tail_reg [LEVELS];
    logic [CntW-1:0] cnt_reg [LEVELS];

    logic                  out_valid_reg;
    status_t               status_reg;
    logic [IdFieldW-1:0]   id_reg;
    logic [LvlFieldW-1:0]  lvl_reg;
    logic [QuantumW-1:0]   quantum_reg;
    logic                  from_ram_reg;

    logic                  accept;
    action_t               action;
    prior_state_t          pstate;
    logic [IdFieldW-1:0]   id_in;
    logic [LvlW-1:0]       old_lvl;
    logic [LvlW-1:0]       enq_lvl;
    logic [LvlW-1:0]       deq_lvl;
    logic                  deq_found;
    logic [LvlW-1:0]       op_lvl;
    logic [PtrW-1:0]       sel_head;
    logic [PtrW-1:0]       sel_tail;
    logic [CntW-1:0]       sel_cnt;
    logic                  do_write;
    logic                  do_read;
    logic [AddrW-1:0]      ram_addr;
    logic [StoreW-1:0]     ram_rd_data;
    status_t               status_next;
    logic [IdFieldW-1:0]   id_next;
    logic [LvlW-1:0]       lvl_next;
    logic [QuantumW-1:0]   quantum_next;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept = s_tvalid && s_tready;

    assign action = action_t'(s_tuser[0]);
    assign id_in = s_tdata[7:0] & IdMask;
    assign pstate = prior_state_t'(s_tdata[11:10]);

    always_comb begin
        if (int'(s_tdata[9:8]) > LEVELS - 1) begin
            old_lvl = LastLvl;
        end else begin
            old_lvl = LvlW'(s_tdata[9:8]);
        end

        if (pstate == PS_BLOCKED) begin
            enq_lvl = (old_lvl != '0) ? old_lvl - LvlW'(1) : '0;
        end else begin
            enq_lvl = (old_lvl < LastLvl) ? old_lvl + LvlW'(1) : LastLvl;
        end

        deq_found = 1'b0;
        deq_lvl = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (cnt_reg[i] != '0) begin
                deq_found = 1'b1;
                deq_lvl = LvlW'(i);
            end
        end

        op_lvl = (action == ACT_ENQUEUE) ? enq_lvl : deq_lvl;
        sel_head = head_reg[op_lvl];
        sel_tail = tail_reg[op_lvl];
        sel_cnt = cnt_reg[op_lvl];

        do_write = 1'b0;
        do_read = 1'b0;
        id_next = id_in;
        lvl_next = op_lvl;
        status_next = ST_OK;
        if (action == ACT_ENQUEUE) begin
            if (pstate == PS_INVALID) begin
                status_next = ST_BAD_STATE;
                lvl_next = '0;
            end else if (sel_cnt == FullCnt) begin
                status_next = ST_FULL;
            end else begin
                do_write = 1'b1;
            end
        end else begin
            if (deq_found) begin
                do_read = 1'b1;
            end else begin
                status_next = ST_EMPTY;
                id_next = '0;
                lvl_next = '0;
            end
        end

        quantum_next = (status_next == ST_OK) ? level_quantum(3'(lvl_next)) : '0;
        ram_addr = {op_lvl, (do_write ? sel_tail : sel_head)};
    end

    mlfq_id_ram #(
        .DATA_W(StoreW),
        .ADDR_W(AddrW)
    ) u_id_ram (
        .aclk    (aclk),
        .wr_en   (accept && do_write),
        .rd_en   (accept && do_read),
        .addr    (ram_addr),
        .wr_data (StoreW'(id_in)),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end else begin
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (accept && do_write) begin
                tail_reg[op_lvl] <= (sel_tail == LastPtr) ? '0 : sel_tail + PtrW'(1);
                cnt_reg[op_lvl] <= sel_cnt + CntW'(1);
            end
            if (accept && do_read) begin
                head_reg[op_lvl] <= (sel_head == LastPtr) ? '0 : sel_head + PtrW'(1);
                cnt_reg[op_lvl] <= sel_cnt - CntW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            id_reg <= id_next;
            lvl_reg <= LvlFieldW'(lvl_next);
            quantum_reg <= quantum_next;
            from_ram_reg <= do_read;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser = status_reg;
    assign m_tdata = {2'b00, quantum_reg, lvl_reg,
                      (from_ram_reg ? IdFieldW'(ram_rd_data) : id_reg)};

endmodule

@@ sv/mlfq_id_ram.sv @@
// ----------------------------------------------------------------------------
// mlfq_id_ram
// Single-port storage for queued process IDs with a registered read.
// ----------------------------------------------------------------------------
module mlfq_id_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the multilevel feedback queue scheduler. A short table
// of directed beats covers empty dequeues, invalid prior states, promotion and
// demotion at the level extremes and the service order across levels. Random
// segments then fill single levels until they overflow, drain them, mix both,
// and throw noise at the block. Every result beat is checked field by field against
// a queue-based prediction or a typed row, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mlfq_pkg::*;

    localparam int QDEPTH = 64;
    localparam int LEVELS = 4;
    localparam int RANDOM_BEATS = 1400;
    localparam int NUM_DIR = 22;

    typedef struct packed {
        status_t    status;
        logic [7:0] id;
        logic [1:0] lvl;
        logic [3:0] quantum;
    } sched_result_t;

    typedef struct {
        action_t       act;
        logic [7:0]    pid;
        logic [1:0]    oldp;
        prior_state_t  pst;
        bit            typed;
        sched_result_t res;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    status_t     m_tuser;

    logic [7:0]    level_fifo [LEVELS][$];
    sched_result_t sched_results_due [$];
    bit            tx_no_gaps;
    bit            rx_no_stall;
    int            err_count;
    int            beats_sent;
    int            n_ok;
    int            n_full;
    int            n_bad;
    int            n_empty;

    dir_row_t dir_rows [NUM_DIR] = '{
        '{ACT_DEQUEUE, 8'h00, 2'd0, PS_READY,   1'b1, '{ST_EMPTY,     8'h00, 2'd0, 4'd0}},
        '{ACT_DEQUEUE, 8'hFF, 2'd3, PS_INVALID, 1'b1, '{ST_EMPTY,     8'h00, 2'd0, 4'd0}},
        '{ACT_ENQUEUE, 8'hFF, 2'd0, PS_READY,   1'b1, '{ST_OK,        8'hFF, 2'd1, 4'd2}},
        '{ACT_ENQUEUE, 8'h00, 2'd3, PS_RUNNING, 1'b1, '{ST_OK,        8'h00, 2'd3, 4'd8}},
        '{ACT_ENQUEUE, 8'h5A, 2'd0, PS_BLOCKED, 1'b1, '{ST_OK,        8'h5A, 2'd0, 4'd1}},
        '{ACT_ENQUEUE, 8'hA5, 2'd3, PS_INVALID, 1'b1, '{ST_BAD_STATE, 8'hA5, 2'd0, 4'd0}},
        '{ACT_ENQUEUE, 8'h3C, 2'd0, PS_INVALID, 1'b1, '{ST_BAD_STATE, 8'h3C, 2'd0, 4'd0}},
        '{ACT_ENQUEUE, 8'h12, 2'd3, PS_BLOCKED, 1'b0, '{ST_OK,        8'h00, 2'd0, 4'd0}},
        '{ACT_ENQUEUE, 8'h34, 2'd1, PS_BLOCKED, 1'b0, '{ST_OK,        8'h00, 2'd0, 4'd0}},
        '{ACT_ENQUEUE, 8'h56, 2'd2, PS_READY,   1'b0, '{ST_OK,        8'h00, 2'd0, 4'd0}},
        '{ACT_ENQUEUE, 8'h78, 2'd1, PS_RUNNING, 1'b0, '{ST_OK,        8'h00, 2'd0, 4'd0}},
        '{ACT_ENQUEUE, 8'hC3, 2'd2, PS_BLOCKED, 1'b0, '{ST_OK,        8'h00, 2'd0, 4'd0}},
        '{ACT_DEQUEUE, 8'h00, 2'd0, PS_READY,   1'b0, '{ST_OK,        8'h00, 2'd0, 4'd0}},
        '{ACT_DEQUEUE, 8'hFF, 2'd3, PS_BLOCKED, 1'b0, '{ST_OK,        8'h00, 2'd0, 4'd0}},
        '{ACT_DEQUEUE, 8'h00, 2'd1, PS_RUNNING, 1'b0, '{ST_OK,        8'h00, 2'd0, 4'd0}},
        '{ACT_DEQUEUE, 8'h00, 2'd0, PS_READY,   1'b0, '{ST_OK,        8'h00, 2'd0, 4'd0}},
        '{ACT_DEQUEUE, 8'h00, 2'd0, PS_READY,   1'b0, '{ST_OK,        8'h00, 2'd0, 4'd0}},
        '{ACT_DEQUEUE, 8'h00, 2'd0, PS_READY,   1'b0, '{ST_OK,        8'h00, 2'd0, 4'd0}},
        '{ACT_DEQUEUE, 8'h00, 2'd0, PS_READY,   1'b0, '{ST_OK,        8'h00, 2'd0, 4'd0}},
        '{ACT_DEQUEUE, 8'h00, 2'd0, PS_READY,   1'b0, '{ST_OK,        8'h00, 2'd0, 4'd0}},
        '{ACT_DEQUEUE, 8'h00, 2'd0, PS_READY,   1'b1, '{ST_EMPTY,     8'h00, 2'd0, 4'd0}},
        '{ACT_ENQUEUE, 8'h81, 2'd0, PS_RUNNING, 1'b0, '{ST_OK,        8'h00, 2'd0, 4'd0}}
    };

    multilevel_feedback_queue_scheduler_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("tb failed");
        $finish;
    end

    function automatic int next_level(input logic [1:0] oldp, input prior_state_t pst);
        int cur;
        cur = (int'(oldp) > LEVELS - 1) ? LEVELS - 1 : int'(oldp);
        if (pst == PS_BLOCKED) begin
            return (cur > 0) ? cur - 1 : 0;
        end
        return (cur < LEVELS - 1) ? cur + 1 : LEVELS - 1;
    endfunction

    function automatic logic [3:0] slice_of(input int lvl);
        return (lvl < 4) ? 4'(1 << lvl) : 4'd8;
    endfunction

    function automatic sched_result_t apply_sched_event(input action_t act,
                                                        input logic [7:0] pid,
                                                        input logic [1:0] oldp,
                                                        input prior_state_t pst);
        sched_result_t r;
        int lvl;
        bit found;
        r = '{ST_EMPTY, 8'h00, 2'd0, 4'd0};
        found = 1'b0;
        if (act == ACT_ENQUEUE) begin
            if (pst == PS_INVALID) begin
                r = '{ST_BAD_STATE, pid, 2'd0, 4'd0};
            end else begin
                lvl = next_level(oldp, pst);
                if (level_fifo[lvl].size() >= QDEPTH) begin
                    r = '{ST_FULL, pid, 2'(lvl), 4'd0};
                end else begin
                    level_fifo[lvl].push_back(pid);
                    r = '{ST_OK, pid, 2'(lvl), slice_of(lvl)};
                end
            end
        end else begin
            for (int l = 0; l < LEVELS; l++) begin
                if (!found && level_fifo[l].size() != 0) begin
                    r = '{ST_OK, level_fifo[l].pop_front(), 2'(l), slice_of(l)};
                    found = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic drive_event(input action_t act, input logic [7:0] pid,
                               input logic [1:0] oldp, input prior_state_t pst,
                               input bit typed, input sched_result_t typed_res);
        int gap;
        sched_result_t r;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, pst, oldp, pid};
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        r = apply_sched_event(act, pid, oldp, pst);
        sched_results_due.push_back(typed ? typed_res : r);
        beats_sent++;
    endtask

    task automatic wait_drained();
        while (sched_results_due.size() != 0) @(posedge aclk);
    endtask

    // Result beats are checked here, independent of how m_tready is driven.
    always @(posedge aclk) begin
        sched_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            case (m_tuser)
                ST_OK:        n_ok++;
                ST_FULL:      n_full++;
                ST_BAD_STATE: n_bad++;
                default:      n_empty++;
            endcase
            if (sched_results_due.size() == 0) begin
                flag_mismatch($sformatf("result beat with nothing pending, tdata %h",
                                        m_tdata));
            end else begin
                e = sched_results_due.pop_front();
                if (m_tuser !== e.status) begin
                    flag_mismatch($sformatf("status %0d, expected %0d", m_tuser, e.status));
                end
                if (m_tdata[7:0] !== e.id) begin
                    flag_mismatch($sformatf("out_id %h, expected %h", m_tdata[7:0], e.id));
                end
                if (m_tdata[9:8] !== e.lvl) begin
                    flag_mismatch($sformatf("new_priority %0d, expected %0d",
                                            m_tdata[9:8], e.lvl));
                end
                if (m_tdata[13:10] !== e.quantum) begin
                    flag_mismatch($sformatf("quantum %0d, expected %0d",
                                            m_tdata[13:10], e.quantum));
                end
            end
        end
    end

    initial begin
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = rx_no_stall ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        int seg_len;
        int mode;
        int tgt;
        int random_sent;
        action_t act;
        logic [7:0] pid;
        logic [1:0] oldp;
        prior_state_t pst;
        bit first_seg;

        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        tx_no_gaps  = 1'b0;
        rx_no_stall = 1'b0;
        err_count   = 0;
        beats_sent  = 0;
        random_sent = 0;
        first_seg   = 1'b1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            drive_event(dir_rows[i].act, dir_rows[i].pid, dir_rows[i].oldp,
                        dir_rows[i].pst, dir_rows[i].typed, dir_rows[i].res);
        end
        s_tvalid <= 1'b0;
        wait_drained();

        while (random_sent < RANDOM_BEATS) begin
            mode        = first_seg ? 1 : $urandom_range(0, 3);
            first_seg   = 1'b0;
            tx_no_gaps  = ($urandom_range(0, 3) == 0);
            rx_no_stall = ($urandom_range(0, 3) == 0);
            tgt         = $urandom_range(0, LEVELS - 1);
            seg_len     = (mode == 1) ? $urandom_range(90, 150) : $urandom_range(40, 140);
            repeat (seg_len) begin
                pid  = 8'($urandom_range(0, 255));
                oldp = 2'($urandom_range(0, 3));
                pst  = prior_state_t'($urandom_range(0, 2));
                case (mode)
                    1: begin
                        act = ($urandom_range(0, 99) < 92) ? ACT_ENQUEUE : ACT_DEQUEUE;
                        if (act == ACT_ENQUEUE) begin
                            while (next_level(oldp, pst) != tgt) begin
                                oldp = 2'($urandom_range(0, 3));
                                pst  = prior_state_t'($urandom_range(0, 2));
                            end
                        end
                    end
                    2: begin
                        act = ($urandom_range(0, 99) < 85) ? ACT_DEQUEUE : ACT_ENQUEUE;
                    end
                    3: begin
                        act = action_t'($urandom_range(0, 1));
                        pst = prior_state_t'($urandom_range(0, 3));
                    end
                    default: begin
                        act = action_t'($urandom_range(0, 1));
                        if ($urandom_range(0, 15) == 0) begin
                            pst = PS_INVALID;
                        end
                    end
                endcase
                drive_event(act, pid, oldp, pst, 1'b0, '{ST_OK, 8'h00, 2'd0, 4'd0});
                random_sent++;
            end
            if ($urandom_range(0, 3) == 0) begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("%0d event beats sent, %0d of them from the directed table",
                 beats_sent, NUM_DIR);
        $display("results seen: %0d ok, %0d queue full, %0d invalid state, %0d all empty",
                 n_ok, n_full, n_bad, n_empty);
        if (err_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/mlfq_pkg.sv
sv/mlfq_id_ram.sv
sv/multilevel_feedback_queue_scheduler_top.sv
sim/tb.sv
